// ----- sv/sls_pkg.sv -----
package sls_pkg;

  localparam int unsigned MaxThreads = 16;
  localparam int unsigned Lanes      = (MaxThreads < 16) ? MaxThreads : 16;
  localparam int unsigned ThrW       = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV1,
    ST_DIV2,
    ST_PREP,
    ST_GEN,
    ST_EMIT
  } sls_state_e;

endpackage

// ----- sv/static_loop_slicer.sv -----
// A rejected loop (empty mask or zero step) passes through ST_SETUP, which registers its error beat.
// Otherwise setup, two 34-step restoring divides (span / step, then count or quotient / N), prep and
// the slice-0 build come before the first beat, then one beat per cycle while the output is not
// stalled and no unused thread slot is passed. Loops do not overlap: in_stall_o is high until the
// loop's last beat is taken.
// Reset: rst_ni async active low clears sequencer and output valid; payload uncleared.
module static_loop_slicer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] loop_lower_i,
  input  logic [31:0] loop_upper_i,
  input  logic [31:0] loop_step_i,
  input  logic [30:0] loop_chunk_i,
  input  logic [15:0] compatible_threads_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  thread_index_o,
  output logic [3:0]  slice_number_o,
  output logic [31:0] slice_lower_o,
  output logic [31:0] slice_upper_o,
  output logic [31:0] slice_step_o,
  output logic [30:0] slice_chunk_o,
  output logic        final_slice_o,
  output logic        interleaved_o,
  output logic        error_o,
  output logic        last_result_o
);
  import sls_pkg::*;

  sls_state_e state_q, state_d;

  // captured loop
  logic signed [31:0] lo_q, hi_q, st_q;
  logic [30:0] ch_q;
  logic [15:0] mask_q;
  logic [4:0]  nv_q;
  logic        err_q;

  // derived
  logic signed [33:0] nit_q;  // iteration count (static) or span quotient
  logic signed [33:0] c_q;    // nit / nv
  logic [4:0]  adj_q;         // nit % nv, zero when nit is negative
  logic signed [31:0] nst_q;
  logic [30:0] och_q;

  // walk
  logic [3:0]  idx_q;         // dense slice number being built
  logic [3:0]  thr_q;         // team thread search pointer
  logic signed [65:0] l_q;    // running static lower / interleaved seed
  logic [3:0]  thr0_q;
  logic signed [65:0] su0_q, sl0_q;
  logic        first_q;

  // divider
  logic        dv_start;
  logic [33:0] dv_dividend;
  logic [31:0] dv_divisor;
  logic        dv_busy;
  logic [33:0] dv_quot;
  logic [31:0] dv_rem;
  logic        div2_go_q;

  sls_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (dv_start),
    .dividend_i(dv_dividend),
    .divisor_i (dv_divisor),
    .busy_o    (dv_busy),
    .quot_o    (dv_quot),
    .rem_o     (dv_rem)
  );

  logic in_fire, out_fire;
  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_fire = out_valid_o && !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  // setup: span and signs
  logic signed [33:0] span;
  logic               span_neg, st_neg;
  logic [33:0]        span_abs;
  logic [31:0]        st_abs;
  assign span     = 34'(hi_q) - 34'(lo_q);
  assign span_neg = span[33];
  assign st_neg   = st_q[31];
  assign span_abs = span_neg ? 34'(-span) : span;
  assign st_abs   = st_neg ? 32'(-st_q) : st_q;

  logic signed [33:0] q1;     // truncating (hi-lo)/st
  logic [4:0] cnt_mask;
  always_comb begin
    cnt_mask = '0;
    for (int t = 0; t < Lanes; t++) cnt_mask = cnt_mask + 5'(mask_q[t]);
  end

  logic signed [33:0] nit1;
  assign q1   = (span_neg ^ st_neg) ? 34'(-dv_quot) : dv_quot;
  assign nit1 = q1 + 34'sd1;

  // static div: nit may be negative; interleaved chunk-1: q1/nv + 1
  logic signed [33:0] dvd2;
  assign dvd2 = (ch_q == '0) ? nit_q : nit_q;
  logic               d2_neg;
  assign d2_neg = dvd2[33];

  // slice build
  logic signed [65:0] stw, u_base, u_cand, hiw;
  logic               down, beyond_u, beyond_s;
  logic signed [33:0] cm1;
  assign stw  = 66'(st_q);
  assign hiw  = 66'(hi_q);
  assign down = st_neg;
  assign cm1  = c_q - 34'sd1;

  logic signed [65:0] prod_q;     // (c-1)*st or ch*st, registered in PREP
  assign u_base = l_q + prod_q + (({1'b0, adj_q} > {2'b0, idx_q}) ? stw : 66'sd0);
  assign beyond_u = down ? (u_base < hiw) : (u_base > hiw);
  assign u_cand  = beyond_u ? hiw : u_base;
  assign beyond_s = down ? (l_q < hiw) : (l_q > hiw);

  logic [30:0] cclamp;
  assign cclamp = c_q[33] ? 31'd0 : ((c_q > 34'sh7FFFFFFF) ? 31'h7FFFFFFF : c_q[30:0]);

  // output register
  logic [3:0]  o_thr_q, o_num_q;
  logic [31:0] o_lo_q, o_hi_q, o_st_q;
  logic [30:0] o_ch_q;
  logic        o_fin_q, o_il_q, o_err_q, o_last_q, o_valid_q;

  logic emit_slot;
  assign emit_slot = !o_valid_q || out_fire;

  // GEN: one slice per cycle when output slot free and the pointed thread is in the mask
  logic gen_done, gen_go, gen_skip, gen_stop;
  logic [3:0] nv4m1;
  assign nv4m1 = 4'(nv_q - 5'd1);
  assign gen_go   = (state_q == ST_GEN) && emit_slot;
  assign gen_skip = (state_q == ST_GEN) && !mask_q[thr_q];
  // interleaved: stop emitting seeds beyond upper; slice 0 is always emitted last
  assign gen_stop = ch_q != '0 && !first_q && beyond_s;
  assign gen_done = gen_go && !gen_skip && !first_q && ((idx_q == '0) || gen_stop);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_fire) state_d = ST_SETUP;
      ST_SETUP: state_d = err_q ? ST_EMIT : ST_DIV1;
      ST_DIV1:  if (!dv_busy && !dv_start) state_d = ST_DIV2;
      ST_DIV2:  if (!dv_busy && !div2_go_q && !dv_start) state_d = ST_PREP;
      ST_PREP:  state_d = ST_GEN;
      ST_GEN:   if (gen_done) state_d = ST_EMIT;
      ST_EMIT:  if (out_fire && o_last_q) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    dv_start    = 1'b0;
    dv_dividend = span_abs;
    dv_divisor  = st_abs;
    if (state_q == ST_SETUP && !err_q) begin
      dv_start = 1'b1;
    end else if (div2_go_q) begin
      dv_start    = 1'b1;
      dv_dividend = d2_neg ? 34'(-dvd2) : dvd2;
      dv_divisor  = 32'(nv_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      o_valid_q <= 1'b0;
      div2_go_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      div2_go_q <= (state_q == ST_DIV1) && !dv_busy && !dv_start;
      if ((state_q == ST_SETUP && err_q) || (gen_go && !gen_skip && !first_q)) begin
        o_valid_q <= 1'b1;
      end else if (out_fire) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  // payload and datapath
  logic signed [33:0] c2;
  logic signed [33:0] och1;
  assign c2   = (d2_neg ^ 1'b0) ? 34'(-dv_quot) : dv_quot;
  assign och1 = c2 + 34'sd1;

  logic signed [65:0] nst64;
  logic signed [65:0] emit_lo, emit_hi;
  logic [3:0]         emit_thr, emit_num;
  logic               emit_last, emit_fin;

  always_comb begin
    nst64 = stw * 66'(nv_q);
    emit_thr  = thr_q;
    emit_num  = idx_q;
    emit_last = 1'b0;
    emit_fin  = 1'b0;
    emit_lo   = l_q;
    emit_hi   = (ch_q == '0) ? u_cand : hiw;
    if (first_q) begin
      // slice 0 built first, stored, emitted last
      emit_last = 1'b0;
    end
    if (ch_q == '0) emit_fin = (idx_q == nv4m1);
    if (!first_q && (idx_q == '0 || gen_stop)) begin
      emit_thr  = thr0_q;
      emit_num  = '0;
      emit_lo   = sl0_q;
      emit_hi   = su0_q;
      emit_last = 1'b1;
      emit_fin  = (ch_q == '0) && (nv_q == 5'd1);
    end
  end

  logic [3:0] idx_nx;
  assign idx_nx = (idx_q == nv4m1) ? 4'd0 : idx_q + 4'd1;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      lo_q   <= loop_lower_i;
      hi_q   <= loop_upper_i;
      st_q   <= loop_step_i;
      ch_q   <= loop_chunk_i;
      mask_q <= compatible_threads_i;
    end
    if (state_q == ST_SETUP) begin
      nv_q  <= cnt_mask;
      err_q <= 1'b0;
      if (err_q) begin
        o_thr_q <= '0; o_num_q <= '0; o_lo_q <= '0; o_hi_q <= '0; o_st_q <= '0;
        o_ch_q <= '0; o_fin_q <= 1'b0; o_il_q <= 1'b0; o_err_q <= 1'b1;
        o_last_q <= 1'b1;
      end
    end
    if (in_fire) begin
      err_q <= (loop_step_i == '0) ||
               ((compatible_threads_i & 16'((17'd1 << Lanes) - 17'd1)) == '0);
    end
    if (state_q == ST_DIV1 && !dv_busy && !dv_start) begin
      nit_q <= (ch_q == '0) ? nit1 : q1;
    end
    if (state_q == ST_DIV2 && !dv_busy && !div2_go_q && !dv_start) begin
      c_q   <= c2;
      // a negative count leaves a negative remainder: no slice gets an extra step
      adj_q <= d2_neg ? 5'd0 : 5'(dv_rem);
      och_q <= (ch_q == 31'd1)
               ? (och1[33] ? 31'd0 : ((och1 > 34'sh7FFFFFFF) ? 31'h7FFFFFFF : och1[30:0]))
               : ch_q;
      if (ch_q == 31'd1) begin
        nst_q <= (nst64 > 66'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                 (nst64 < -66'sh80000000) ? 32'sh80000000 : nst64[31:0];
      end else begin
        nst_q <= st_q;
      end
    end
    if (state_q == ST_PREP) begin
      prod_q  <= (ch_q == '0) ? 66'(cm1) * stw : 66'($signed({1'b0, ch_q})) * stw;
      l_q     <= 66'(lo_q);
      idx_q   <= '0;
      thr_q   <= '0;
      first_q <= 1'b1;
    end
    if (gen_skip) thr_q <= thr_q + 4'd1;
    if (gen_go && !gen_skip) begin
      if (first_q) begin
        thr0_q  <= thr_q;
        sl0_q   <= l_q;
        su0_q   <= (ch_q == '0) ? u_cand : hiw;
        first_q <= 1'b0;
        if (ch_q == '0) l_q <= u_cand + stw;
        else            l_q <= l_q + prod_q;
        idx_q   <= idx_nx;
        thr_q   <= thr_q + 4'd1;
      end else begin
        o_thr_q  <= emit_thr;
        o_num_q  <= emit_num;
        o_lo_q   <= emit_lo[31:0];
        o_hi_q   <= emit_hi[31:0];
        o_st_q   <= (ch_q == '0) ? st_q : nst_q;
        o_ch_q   <= (ch_q == '0) ? cclamp : och_q;
        o_fin_q  <= emit_fin;
        o_il_q   <= (ch_q != '0);
        o_err_q  <= 1'b0;
        o_last_q <= emit_last;
        if (emit_last) begin
          idx_q <= '0;
        end else begin
          if (ch_q == '0) l_q <= u_cand + stw;
          else            l_q <= l_q + prod_q;
          idx_q <= idx_nx;
          thr_q <= thr_q + 4'd1;
        end
      end
    end
  end

  assign out_valid_o    = o_valid_q;
  assign thread_index_o = o_thr_q;
  assign slice_number_o = o_num_q;
  assign slice_lower_o  = o_lo_q;
  assign slice_upper_o  = o_hi_q;
  assign slice_step_o   = o_st_q;
  assign slice_chunk_o  = o_ch_q;
  assign final_slice_o  = o_fin_q;
  assign interleaved_o  = o_il_q;
  assign error_o        = o_err_q;
  assign last_result_o  = o_last_q;

  // no new loop while results are pending
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("accept while busy");
  // error beats are always the last of their loop
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_o) |-> last_result_o) else $error("error not last");
  // after the last beat goes, the block returns to idle
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && last_result_o) |=> !in_stall_o) else $error("not idle");
endmodule

// ----- sv/sls_div.sv -----
module sls_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [33:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        busy_o,
  output logic [33:0] quot_o,
  output logic [31:0] rem_o
);
  import sls_pkg::*;

  logic [5:0]  cnt_q, cnt_d;
  logic [33:0] q_q, q_d;
  logic [32:0] r_q, r_d;
  logic [31:0] dv_q, dv_d;
  logic [32:0] trial;

  always_comb begin
    cnt_d = cnt_q;
    q_d   = q_q;
    r_d   = r_q;
    dv_d  = dv_q;
    trial = '0;
    if (start_i) begin
      cnt_d = 6'd34;
      q_d   = dividend_i;
      r_d   = '0;
      dv_d  = divisor_i;
    end else if (cnt_q != '0) begin
      trial = {r_q[31:0], q_q[33]};
      if (trial >= {1'b0, dv_q}) begin
        r_d = trial - {1'b0, dv_q};
        q_d = {q_q[32:0], 1'b1};
      end else begin
        r_d = trial;
        q_d = {q_q[32:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q  <= q_d;
    r_q  <= r_d;
    dv_q <= dv_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = q_q;
  assign rem_o  = r_q[31:0];
endmodule

// ----- dv/static_loop_slicer_tb.sv -----
module static_loop_slicer_tb;
  import sls_pkg::*;

  // one expected output beat
  typedef struct {
    logic [3:0]  thr;
    logic [3:0]  num;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] st;
    logic [30:0] ch;
    logic        fin;
    logic        il;
    logic        err;
    logic        last;
  } slice_t;

  localparam int IdleLimit = 20000;   // cycles with no beat on either side
  localparam int DrainWait = 100;     // cycles to wait after the last expected beat

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] loop_lower_i;
  logic [31:0] loop_upper_i;
  logic [31:0] loop_step_i;
  logic [30:0] loop_chunk_i;
  logic [15:0] compatible_threads_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [3:0]  thread_index_o;
  logic [3:0]  slice_number_o;
  logic [31:0] slice_lower_o;
  logic [31:0] slice_upper_o;
  logic [31:0] slice_step_o;
  logic [30:0] slice_chunk_o;
  logic        final_slice_o;
  logic        interleaved_o;
  logic        error_o;
  logic        last_result_o;

  slice_t pending_slices[$];
  int     err_count;
  int     idle_cycles;
  int     stall_pct;      // receiver stall rate in percent, changed per test
  int     gap_max;        // longest sender gap between bursts

  static_loop_slicer DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Prediction: splits one loop the way the block must.
  // All bound math is done in 64-bit signed to match the wide comparisons.
  // ---------------------------------------------------------------------
  function automatic logic [30:0] clip_chunk(longint c);
    if (c < 0) return '0;
    if (c > 64'sh7fffffff) return 31'h7fffffff;
    return c[30:0];
  endfunction

  function automatic void queue_slice(int thr, int num, longint lo, longint hi, longint st,
                                      logic [30:0] ch, bit fin, bit il, bit err, bit last);
    slice_t s;
    s.thr = thr[3:0];  s.num = num[3:0];
    s.lo = lo[31:0];   s.hi = hi[31:0];  s.st = st[31:0];
    s.ch = ch;  s.fin = fin;  s.il = il;  s.err = err;  s.last = last;
    pending_slices.push_back(s);
  endfunction

  function automatic void predict_slices(logic [31:0] lo_v, logic [31:0] hi_v,
                                         logic [31:0] st_v, logic [30:0] ch_v,
                                         logic [15:0] mask);
    longint lo, hi, st, ch, nit, adj, c, l, u, off, nst, seed;
    longint sl[16];
    longint su[16];
    int thr_of[16];
    int nv;
    bit down;
    logic [30:0] och;
    lo = longint'($signed(lo_v));
    hi = longint'($signed(hi_v));
    st = longint'($signed(st_v));
    ch = longint'({33'b0, ch_v});
    down = st < 0;
    nv = 0;
    for (int t = 0; t < int'(Lanes); t++)
      if (mask[t]) begin
        thr_of[nv] = t;
        nv++;
      end
    // no usable thread or zero step: a lone error beat, all else zero
    if (nv == 0 || st == 0) begin
      queue_slice(0, 0, '0, '0, '0, '0, 1'b0, 1'b0, 1'b1, 1'b1);
      return;
    end
    if (ch == 0) begin
      // static: near-equal contiguous slices, the first adj get one extra
      nit = (hi - lo) / st + 1;
      adj = nit % nv;
      c   = nit / nv;
      l   = lo;
      for (int i = 0; i < nv; i++) begin
        if (i > 0) l = su[i-1] + st;
        u = l + (c - 1) * st + ((adj > i) ? st : 0);
        if (down ? (u < hi) : (u > hi)) u = hi;
        sl[i] = l;
        su[i] = u;
      end
      for (int i = 1; i < nv; i++)
        queue_slice(thr_of[i], i, sl[i], su[i], st, clip_chunk(c), i == nv - 1,
                    1'b0, 1'b0, 1'b0);
      queue_slice(thr_of[0], 0, sl[0], su[0], st, clip_chunk(c), nv == 1, 1'b0, 1'b0, 1'b1);
    end else begin
      // interleaved: one seed per thread; chunk 1 widens the step by N
      off = ch * st;
      nst = st;
      och = clip_chunk(ch);
      if (ch == 1) begin
        och = clip_chunk(((hi - lo) / st) / nv + 1);
        nst = st * nv;
        if (nst > 64'sh7fffffff) nst = 64'sh7fffffff;
        if (nst < -64'sh80000000) nst = -64'sh80000000;
      end
      for (int i = 1; i < nv; i++) begin
        seed = lo + longint'(i) * off;
        if (down ? (seed < hi) : (seed > hi)) break;   // seeds past the end stop
        queue_slice(thr_of[i], i, seed, hi, nst, och, 1'b0, 1'b1, 1'b0, 1'b0);
      end
      queue_slice(thr_of[0], 0, lo, hi, nst, och, 1'b0, 1'b1, 1'b0, 1'b1);
    end
  endfunction

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    err_count++;
  endtask

  always @(posedge clk_i) begin
    slice_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_slices.size() == 0) begin
        report_mismatch("unexpected beat", {28'b0, thread_index_o}, '0);
      end else begin
        e = pending_slices.pop_front();
        if (thread_index_o !== e.thr)
          report_mismatch("thread_index", 32'(thread_index_o), 32'(e.thr));
        if (slice_number_o !== e.num)
          report_mismatch("slice_number", 32'(slice_number_o), 32'(e.num));
        if (slice_lower_o !== e.lo) report_mismatch("slice_lower", slice_lower_o, e.lo);
        if (slice_upper_o !== e.hi) report_mismatch("slice_upper", slice_upper_o, e.hi);
        if (slice_step_o !== e.st) report_mismatch("slice_step", slice_step_o, e.st);
        if (slice_chunk_o !== e.ch)
          report_mismatch("slice_chunk", 32'(slice_chunk_o), 32'(e.ch));
        if (final_slice_o !== e.fin)
          report_mismatch("final_slice", 32'(final_slice_o), 32'(e.fin));
        if (interleaved_o !== e.il)
          report_mismatch("interleaved", 32'(interleaved_o), 32'(e.il));
        if (error_o !== e.err) report_mismatch("error", 32'(error_o), 32'(e.err));
        if (last_result_o !== e.last)
          report_mismatch("last_result", 32'(last_result_o), 32'(e.last));
      end
    end
  end

  // receiver stall pattern, random at stall_pct percent, stall-free when stall_pct is 0
  always @(negedge clk_i)
    out_stall_i <= rst_ni && ($urandom_range(99) < stall_pct);

  // watchdog: counts cycles in which no beat moves on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  // drive one loop at the falling edge and hold it until taken
  task automatic send_loop(logic [31:0] lo, logic [31:0] hi, logic [31:0] st,
                           logic [30:0] ch, logic [15:0] mask);
    @(negedge clk_i);
    in_valid_i = 1'b1;
    loop_lower_i = lo;
    loop_upper_i = hi;
    loop_step_i = st;
    loop_chunk_i = ch;
    compatible_threads_i = mask;
    do @(posedge clk_i); while (in_stall_o);
    predict_slices(lo, hi, st, ch, mask);
  endtask

  task automatic idle_gap();
    int n;
    n = $urandom_range(gap_max);
    for (int i = 0; i < n; i++) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
  endtask

  task automatic test_directed();
    stall_pct = 0;
    send_loop(0, 99, 1, 31'd0, 16'h0000);                   // empty mask
    send_loop(0, 99, 0, 31'd0, 16'hffff);                   // zero step
    send_loop(0, 99, 0, 31'd5, 16'h0000);                   // both errors
    send_loop(0, 99, 1, 31'd0, 16'h0001);                   // one thread
    send_loop(0, 99, 1, 31'd0, 16'hffff);                   // all threads
    send_loop(0, 10, 1, 31'd0, 16'ha5a5);                   // uneven split
    send_loop(100, 3, -7, 31'd0, 16'h8421);                 // counting down
    send_loop(0, 5, 1, 31'd0, 16'hffff);                    // fewer iters than threads
    send_loop(10, 0, 1, 31'd0, 16'h00ff);                   // empty static loop
    send_loop(32'h80000000, 32'h7fffffff, 1, 31'd0, 16'hffff);  // widest span
    send_loop(32'h7fffffff, 32'h80000000, 32'h80000000, 31'd0, 16'hffff);
    send_loop(32'h80000000, 32'h7fffffff, 32'h7fffffff, 31'd0, 16'h7fff);
    stall_pct = 40;
    send_loop(0, 99, 1, 31'd1, 16'hffff);                   // chunk 1 widening
    send_loop(0, 99, 32'h7fffffff, 31'd1, 16'hffff);        // widened step saturates
    send_loop(0, -99, 32'h80000000, 31'd1, 16'h0f0f);       // saturates negative
    send_loop(0, 99, 3, 31'd4, 16'hffff);                   // seeds run past the end
    send_loop(50, -50, -2, 31'd7, 16'h3c3c);
    send_loop(0, 99, 1, 31'h7fffffff, 16'hffff);            // largest chunk
    send_loop(32'h80000000, 32'h7fffffff, 32'h80000000, 31'h7fffffff, 16'hffff);
    send_loop(5, 4, 1, 31'd2, 16'h00f0);                    // empty interleaved loop
    send_loop(-3, 40, 3, 31'd0, 16'h8000);                  // top thread only
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // mostly small, meaningful loops; some fully random operands
  task automatic test_random(int count, int chunk_mode);
    logic [31:0] lo, hi, st;
    logic [30:0] ch;
    logic [15:0] mask;
    int sent, burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 6);
      for (int b = 0; b < burst && sent < count; b++) begin
        if ($urandom_range(9) < 2) begin
          lo = $urandom(); hi = $urandom(); st = $urandom();
        end else begin
          lo = $urandom_range(400) - 200;
          hi = $urandom_range(400) - 200;
          st = $urandom_range(15) - 7;
          if ($urandom_range(9) == 0) st = 0;
        end
        case (chunk_mode)
          0: ch = '0;
          1: ch = 31'd1;
          default: ch = ($urandom_range(3) == 0) ? 31'($urandom()) : 31'($urandom_range(1, 8));
        endcase
        case ($urandom_range(5))
          0: mask = 16'h0001 << $urandom_range(15);
          1: mask = 16'hffff;
          2: mask = ($urandom_range(7) == 0) ? 16'h0000 : 16'($urandom());
          default: mask = 16'($urandom());
        endcase
        send_loop(lo, hi, st, ch, mask);
        sent++;
      end
      idle_gap();
    end
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  initial begin
    err_count = 0;
    idle_cycles = 0;
    stall_pct = 0;
    gap_max = 4;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    loop_lower_i = '0;
    loop_upper_i = '0;
    loop_step_i = '0;
    loop_chunk_i = '0;
    compatible_threads_i = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    stall_pct = 0;   gap_max = 0;  test_random(120, 0);   // static, no idling
    stall_pct = 30;  gap_max = 5;  test_random(120, 0);   // static, both sides idle
    stall_pct = 50;  gap_max = 3;  test_random(100, 1);   // chunk 1 widening
    stall_pct = 20;  gap_max = 8;  test_random(110, 2);   // general interleaved

    wait (pending_slices.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
    if (err_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
